[design/f2c_pkg.sv]
// Package for the Frenet-to-Cartesian converter: payload structs, constants,
// controller/datapath command and status types. No dependencies.
package f2c_pkg;

   localparam int MaxWaypoints = 256;
   localparam int IdxW         = $clog2(MaxWaypoints);
   localparam int CntW         = IdxW + 1;
   localparam int CordicSteps  = 24;
   localparam int StepW        = $clog2(CordicSteps);
   localparam int VecW         = 61;
   localparam int RotW         = 62;
   localparam logic signed [31:0] GainQ30 = 32'sd652032874;

   localparam logic OpWrite   = 1'b0;
   localparam logic OpConvert = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [7:0]         entry_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_arc;
      logic signed [31:0] query_s;
      logic signed [31:0] query_d;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_x;
      logic signed [31:0] result_y;
      logic [7:0]         segment_start;
   } rsp_type;

   typedef struct packed {
      logic            load;
      logic            write;
      logic            rd_start;
      logic [IdxW-1:0] rd_addr;
      logic            take_arc;
      logic            take_start;
      logic            take_next;
      logic            vec_init;
      logic            vec_step;
      logic            rot_init;
      logic            rot_step;
      logic [StepW-1:0] step;
      logic            finish;
   } ctl_type;

   typedef struct packed {
      logic qs_above;
   } sts_type;

endpackage

[design/f2c_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module f2c_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[design/f2c_datapath.sv]
// Datapath: waypoint RAMs, segment operands, CORDIC vectoring and rotation.
// Depends on f2c_pkg and f2c_ram.
module f2c_datapath (
   input  logic              clock,
   input  f2c_pkg::req_type  req,
   input  f2c_pkg::ctl_type  ctl,
   output f2c_pkg::sts_type  sts,
   output f2c_pkg::rsp_type  rsp_data
);
   import f2c_pkg::*;

   logic [31:0] rd_x, rd_y, rd_arc;
   req_type req_ff;
   logic signed [31:0] sx_ff, sy_ff, arc_ff, nx_ff, ny_ff;
   logic [IdxW-1:0] seg_ff;
   logic signed [VecW-1:0] vx_ff, vy_ff;
   logic signed [RotW-1:0] px_ff, py_ff;
   logic [CordicSteps-1:0] cw_ff;
   logic half_ff, zero_ff;
   logic signed [VecW-1:0] dx, dy, vxs, vys;
   logic signed [RotW-1:0] pxs, pys, ax, ay;
   logic signed [63:0] prod_a, prod_c;
   logic signed [33:0] rx, ry;
   logic signed [32:0] along;

   f2c_ram #(.Width(32), .Depth(MaxWaypoints)) u_ram_x (
      .clock, .wr_en(ctl.write), .wr_addr(req_ff.entry_index[IdxW-1:0]),
      .wr_data(req_ff.point_x), .rd_addr(ctl.rd_addr), .rd_data(rd_x));
   f2c_ram #(.Width(32), .Depth(MaxWaypoints)) u_ram_y (
      .clock, .wr_en(ctl.write), .wr_addr(req_ff.entry_index[IdxW-1:0]),
      .wr_data(req_ff.point_y), .rd_addr(ctl.rd_addr), .rd_data(rd_y));
   f2c_ram #(.Width(32), .Depth(MaxWaypoints)) u_ram_arc (
      .clock, .wr_en(ctl.write), .wr_addr(req_ff.entry_index[IdxW-1:0]),
      .wr_data(req_ff.point_arc), .rd_addr(ctl.rd_addr), .rd_data(rd_arc));

   assign sts.qs_above = req_ff.query_s > $signed(rd_arc);

   assign dx = VecW'($signed({{(VecW-32){nx_ff[31]}}, nx_ff})
               - $signed({{(VecW-32){sx_ff[31]}}, sx_ff})) <<< 26;
   assign dy = VecW'($signed({{(VecW-32){ny_ff[31]}}, ny_ff})
               - $signed({{(VecW-32){sy_ff[31]}}, sy_ff})) <<< 26;
   assign vxs = vx_ff >>> ctl.step;
   assign vys = vy_ff >>> ctl.step;
   assign pxs = px_ff >>> ctl.step;
   assign pys = py_ff >>> ctl.step;
   assign along = 33'(req_ff.query_s) - 33'(arc_ff);
   assign prod_a = 64'(along) * 64'(GainQ30);
   assign prod_c = -(64'(req_ff.query_d) * 64'(GainQ30));
   assign ax = RotW'(prod_a >>> 8);
   assign ay = RotW'(prod_c >>> 8);

   always_comb begin
      if (zero_ff) begin
         rx = 34'(sx_ff) + 34'(along);
         ry = 34'(sy_ff) - 34'(req_ff.query_d);
      end else begin
         rx = 34'(sx_ff) + 34'((px_ff + RotW'(64'sd1 <<< 21)) >>> 22);
         ry = 34'(sy_ff) + 34'((py_ff + RotW'(64'sd1 <<< 21)) >>> 22);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req;
      if (ctl.rd_start) seg_ff <= ctl.rd_addr;
      if (ctl.take_arc) arc_ff <= rd_arc;
      if (ctl.take_start) begin
         sx_ff <= rd_x;
         sy_ff <= rd_y;
      end
      if (ctl.take_next) begin
         nx_ff <= rd_x;
         ny_ff <= rd_y;
      end
      if (ctl.vec_init) begin
         zero_ff <= (nx_ff == sx_ff) && (ny_ff == sy_ff);
         half_ff <= dx < 0;
         vx_ff   <= (dx < 0) ? -dx : dx;
         vy_ff   <= (dx < 0) ? -dy : dy;
      end else if (ctl.vec_step) begin
         cw_ff[ctl.step] <= ~vy_ff[VecW-1];
         if (!vy_ff[VecW-1]) begin
            vx_ff <= vx_ff + vys;
            vy_ff <= vy_ff - vxs;
         end else begin
            vx_ff <= vx_ff - vys;
            vy_ff <= vy_ff + vxs;
         end
      end
      if (ctl.rot_init) begin
         px_ff <= half_ff ? -ax : ax;
         py_ff <= half_ff ? -ay : ay;
      end else if (ctl.rot_step) begin
         if (cw_ff[ctl.step]) begin
            px_ff <= px_ff - pys;
            py_ff <= py_ff + pxs;
         end else begin
            px_ff <= px_ff + pys;
            py_ff <= py_ff - pxs;
         end
      end
      if (ctl.finish) begin
         rsp_data.result_x <= (rx > 34'sd2147483647) ? 32'sh7fffffff :
                              (rx < -34'sd2147483648) ? 32'sh80000000 : rx[31:0];
         rsp_data.result_y <= (ry > 34'sd2147483647) ? 32'sh7fffffff :
                              (ry < -34'sd2147483648) ? 32'sh80000000 : ry[31:0];
         rsp_data.segment_start <= 8'(seg_ff);
      end
   end
endmodule

[design/f2c_control.sv]
// Controller: sequences RAM search, operand fetch and both CORDIC passes.
// Depends on f2c_pkg.
module f2c_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             op,
   input  logic [8:0]       count_raw,
   input  f2c_pkg::sts_type sts,
   output f2c_pkg::ctl_type ctl,
   output logic             busy,
   output logic             rsp_valid
);
   import f2c_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_WRITE = 10'b0000000010,
      S_SRCH  = 10'b0000000100,
      S_CHK   = 10'b0000001000,
      S_FST   = 10'b0000010000,
      S_FNX   = 10'b0000100000,
      S_INIT  = 10'b0001000000,
      S_VEC   = 10'b0010000000,
      S_ROT   = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] seg_ff, seg_in, count;
   logic [StepW-1:0] step_ff, step_in;
   logic out_ff;
   logic [CntW-1:0] nxt;

   assign count = (count_raw < 9'd2) ? CntW'(2) :
                  (count_raw > 9'(MaxWaypoints)) ? CntW'(MaxWaypoints) : CntW'(count_raw);
   assign nxt = (seg_ff + 1'b1 == count) ? '0 : seg_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      seg_in = seg_ff;
      step_in = step_ff;
      ctl = '0;
      ctl.step = step_ff;
      ctl.rd_addr = IdxW'(seg_ff + 1'b1);
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               seg_in = '0;
               state_in = (op == OpConvert) ? S_SRCH : S_WRITE;
            end
         end
         S_WRITE: begin
            ctl.write = 1'b1;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (seg_ff + 1'b1 < count) state_in = S_CHK;
            else begin
               ctl.rd_addr = IdxW'(seg_ff);
               ctl.rd_start = 1'b1;
               state_in = S_FST;
            end
         end
         S_CHK: begin
            if (sts.qs_above) begin
               seg_in = seg_ff + 1'b1;
               state_in = S_SRCH;
            end else begin
               ctl.rd_addr = IdxW'(seg_ff);
               ctl.rd_start = 1'b1;
               state_in = S_FST;
            end
         end
         S_FST: begin
            ctl.take_arc = 1'b1;
            ctl.take_start = 1'b1;
            ctl.rd_addr = IdxW'(nxt);
            state_in = S_FNX;
         end
         S_FNX: begin
            ctl.take_next = 1'b1;
            state_in = S_INIT;
         end
         S_INIT: begin
            ctl.vec_init = 1'b1;
            step_in = '0;
            state_in = S_VEC;
         end
         S_VEC: begin
            ctl.vec_step = 1'b1;
            if (step_ff == StepW'(CordicSteps - 1)) begin
               step_in = '0;
               ctl.rot_init = 1'b1;
               state_in = S_ROT;
            end else step_in = step_ff + 1'b1;
         end
         S_ROT: begin
            ctl.rot_step = 1'b1;
            if (step_ff == StepW'(CordicSteps - 1)) state_in = S_DONE;
            else step_in = step_ff + 1'b1;
         end
         S_DONE: begin
            ctl.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff <= ctl.finish;
      end
      seg_ff <= seg_in;
      step_ff <= step_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = out_ff;
endmodule

[design/frenet_to_cartesian.sv]
// Frenet-to-Cartesian converter top level: waypoint table and conversion.
// Depends on f2c_pkg, f2c_control, f2c_datapath.
//
// Usage: present a transaction on req_data with start high while busy is low.
// A waypoint write (operation 0) stores x, y and arc length at entry_index
// and holds busy for one cycle; it gives no result.
// A convert (operation 1) searches the table one entry at a time from entry 0,
// fetches the segment start and end, runs 24 CORDIC vectoring steps and 24
// rotation steps, then saturates. One convert at a time: busy drops in the
// result cycle, so the next start can be taken then.
// The result appears on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall it.
// csr_valid/csr_ready write waypoint_count; ready is always high; write only
// while idle. Reset (synchronous) sets count to 2 and returns to idle; the
// waypoint table is not cleared and entries read before written are undefined.
module frenet_to_cartesian (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  f2c_pkg::req_type req_data,
   output logic             rsp_valid,
   output f2c_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data
);
   import f2c_pkg::*;

   logic [8:0] count_ff;
   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) count_ff <= 9'd2;
      else if (csr_valid) count_ff <= csr_data;
   end

   f2c_control u_control (
      .clock, .reset, .start, .op(req_data.operation), .count_raw(count_ff),
      .sts, .ctl, .busy, .rsp_valid);

   f2c_datapath u_datapath (
      .clock, .req(req_data), .ctl, .sts, .rsp_data);
endmodule

[design/f2c_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on no package; all bound ports are single-bit logic.
module f2c_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic csr_ready
);
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");
   a_busy_on_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   a_rsp_ends_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy)) else $error("stray result");
   a_csr_ready: assert property (@(posedge clock) csr_ready)
      else $error("csr not ready");
endmodule

bind frenet_to_cartesian f2c_checker u_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .csr_ready);

[tb/tb_top.sv]
// Self-checking testbench for frenet_to_cartesian: directed table, then random
// waypoint tables and Frenet queries checked against an in-bench predictor.
// Depends on f2c_pkg and the frenet_to_cartesian RTL.
module tb_top;
   import f2c_pkg::*;

   typedef struct {
      logic    op;
      int      idx;
      longint  x, y, arc, s, d;
      bit      typed;
      rsp_type want;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [8:0] csr_data = 9'd2;

   longint  wp_x [MaxWaypoints];
   longint  wp_y [MaxWaypoints];
   longint  wp_arc [MaxWaypoints];
   int      wp_count = 2;
   rsp_type pending_points [$];
   int      n_errors = 0;
   int      n_points = 0;
   int      n_sent = 0;
   int      burst_left = 0;
   row_type directed [$];

   frenet_to_cartesian u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #64000000;
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int live_count();
      if (wp_count < 2) return 2;
      if (wp_count > MaxWaypoints) return MaxWaypoints;
      return wp_count;
   endfunction

   // segment search, CORDIC vectoring on the heading, replay on (along, -d)
   function automatic rsp_type frenet_point(longint qs, longint qd);
      int      n, seg, nxt;
      longint  sx, sy, along, across, vx, vy, px, py, t, rx, ry;
      bit      half;
      logic [CordicSteps-1:0] cw;
      rsp_type r;
      n = live_count();
      seg = 0;
      while (seg + 1 < n && qs > wp_arc[seg+1]) seg++;
      nxt = (seg + 1) % n;
      sx = wp_x[seg];
      sy = wp_y[seg];
      along = qs - wp_arc[seg];
      across = -qd;
      vx = wp_x[nxt] - sx;
      vy = wp_y[nxt] - sy;
      if (vx == 0 && vy == 0) begin
         rx = sx + along;
         ry = sy + across;
      end else begin
         vx = vx <<< 26;
         vy = vy <<< 26;
         half = 1'b0;
         cw = '0;
         if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            half = 1'b1;
         end
         for (int i = 0; i < CordicSteps; i++) begin
            t = vx;
            if (vy >= 0) begin
               cw[i] = 1'b1;
               vx = vx + (vy >>> i);
               vy = vy - (t >>> i);
            end else begin
               vx = vx - (vy >>> i);
               vy = vy + (t >>> i);
            end
         end
         px = (along * longint'(GainQ30)) >>> 8;
         py = (across * longint'(GainQ30)) >>> 8;
         if (half) begin
            px = -px;
            py = -py;
         end
         for (int i = 0; i < CordicSteps; i++) begin
            t = px;
            if (cw[i]) begin
               px = px - (py >>> i);
               py = py + (t >>> i);
            end else begin
               px = px + (py >>> i);
               py = py - (t >>> i);
            end
         end
         rx = sx + ((px + (64'sd1 <<< 21)) >>> 22);
         ry = sy + ((py + (64'sd1 <<< 21)) >>> 22);
      end
      r.result_x = 32'(sat32(rx));
      r.result_y = 32'(sat32(ry));
      r.segment_start = 8'(seg);
      return r;
   endfunction

   // burst/gap pacing, then one transaction; predictor runs at acceptance
   task automatic send_item(row_type rw);
      req_type q;
      int      gap;
      q = '0;
      q.operation = rw.op;
      q.entry_index = 8'(rw.idx);
      q.point_x = 32'(rw.x);
      q.point_y = 32'(rw.y);
      q.point_arc = 32'(rw.arc);
      q.query_s = 32'(rw.s);
      q.query_d = 32'(rw.d);
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (busy);
      n_sent++;
      if (rw.op == OpWrite) begin
         wp_x[rw.idx] = longint'(q.point_x);
         wp_y[rw.idx] = longint'(q.point_y);
         wp_arc[rw.idx] = longint'(q.point_arc);
      end else begin
         pending_points.insert(pending_points.size(),
                               rw.typed ? rw.want : frenet_point(q.query_s, q.query_d));
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_points.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(int value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= 9'(value);
      do @(posedge clock); while (!csr_ready);
      wp_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic row_type mk(logic op, int idx, longint x, longint y, longint arc,
                                  longint s, longint d);
      row_type rw;
      rw.op = op; rw.idx = idx; rw.x = x; rw.y = y; rw.arc = arc;
      rw.s = s; rw.d = d; rw.typed = 1'b0; rw.want = '0;
      return rw;
   endfunction

   function automatic void add_row(row_type rw);
      directed.insert(directed.size(), rw);
   endfunction

   function automatic longint rnd32();
      return longint'($signed($urandom()));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            $error("unexpected result x=%h y=%h seg=%0d", rsp_data.result_x,
                   rsp_data.result_y, rsp_data.segment_start);
            n_errors++;
         end else begin
            rsp_type w;
            w = pending_points.pop_front();
            n_points++;
            if (rsp_data.result_x !== w.result_x) begin
               $error("result_x: expected %h, got %h", w.result_x, rsp_data.result_x);
               n_errors++;
            end
            if (rsp_data.result_y !== w.result_y) begin
               $error("result_y: expected %h, got %h", w.result_y, rsp_data.result_y);
               n_errors++;
            end
            if (rsp_data.segment_start !== w.segment_start) begin
               $error("segment_start: expected %0d, got %0d", w.segment_start,
                      rsp_data.segment_start);
               n_errors++;
            end
         end
      end
   end

   initial begin
      int      counts [$];
      int      n, limit;
      longint  base, lo, hi, s, d, x, y;
      row_type rw;

      foreach (wp_x[i]) begin
         wp_x[i] = 0; wp_y[i] = 0; wp_arc[i] = 0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-length segment first: results readable at a glance
      add_row(mk(OpWrite, 0, 0, 0, 0, 0, 0));
      add_row(mk(OpWrite, 1, 0, 0, 100 <<< 16, 0, 0));
      rw = mk(OpConvert, 0, 0, 0, 0, 5 <<< 16, 3 <<< 16);
      rw.typed = 1; rw.want = '{32'h0005_0000, 32'hfffd_0000, 8'd0};
      add_row(rw);
      rw = mk(OpConvert, 0, 0, 0, 0, 64'sd2147483647, -64'sd2147483648);
      rw.typed = 1; rw.want = '{32'h7f9b_ffff, 32'h7fff_ffff, 8'd1};
      add_row(rw);
      rw = mk(OpConvert, 0, 0, 0, 0, -64'sd2147483648, 64'sd2147483647);
      rw.typed = 1; rw.want = '{32'h8000_0000, 32'h8000_0001, 8'd0};
      add_row(rw);
      add_row(mk(OpWrite, 1, 10 <<< 16, 0, 100 <<< 16, 0, 0));
      add_row(mk(OpConvert, 0, 0, 0, 0, 40 <<< 16, 2 <<< 16));
      add_row(mk(OpConvert, 0, 0, 0, 0, 150 <<< 16, -(7 <<< 16)));
      add_row(mk(OpWrite, 1, 0, -(10 <<< 16), 100 <<< 16, 0, 0));
      add_row(mk(OpConvert, 0, 0, 0, 0, 30 <<< 16, 1 <<< 16));
      add_row(mk(OpWrite, 1, -64'sd2147483648, 64'sd2147483647,
                 64'sd2147483647, 0, 0));
      add_row(mk(OpConvert, 0, 0, 0, 0, 50 <<< 16, 5 <<< 16));
      add_row(mk(OpConvert, 0, 0, 0, 0, 64'sd2147483647, 0));
      add_row(mk(OpWrite, 0, 64'sd2147483647, -64'sd2147483648,
                 -64'sd2147483648, 0, 0));
      add_row(mk(OpConvert, 0, 0, 0, 0, -64'sd2147483648, -64'sd2147483648));
      add_row(mk(OpConvert, 0, 0, 0, 0, 0, 64'sd2147483647));
      add_row(mk(OpWrite, 255, -1, -1, -1, 0, 0));
      add_row(mk(OpWrite, 0, 3 <<< 16, 4 <<< 16, 0, 0, 0));
      add_row(mk(OpWrite, 1, -(5 <<< 16), 9 <<< 16, 20 <<< 16, 0, 0));
      add_row(mk(OpConvert, 0, 0, 0, 0, 10 <<< 16, -(3 <<< 16)));
      foreach (directed[i]) send_item(directed[i]);

      counts = '{256, 2, 0, 1, 5, 17, 3, 9, 257, 40, 2, 7, 12, 4};
      foreach (counts[p]) begin
         write_count(counts[p]);
         n = live_count();
         // well-formed table: nondecreasing arcs, some zero-length segments
         base = longint'($urandom_range(0, 1 << 29)) - (1 <<< 28);
         for (int e = 0; e < n; e++) begin
            if (e > 0 && $urandom_range(0, 9) == 0) begin
               x = wp_x[e-1]; y = wp_y[e-1];
            end else if ($urandom_range(0, 15) == 0) begin
               x = rnd32(); y = rnd32();
            end else begin
               x = longint'($urandom_range(0, 1 << 27)) - (1 <<< 26);
               y = longint'($urandom_range(0, 1 << 27)) - (1 <<< 26);
            end
            if (e > 0) base += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 1 << 20);
            send_item(mk(OpWrite, e, x, y, base, 0, 0));
         end
         lo = wp_arc[0] - (8 <<< 16);
         hi = base + (8 <<< 16);
         limit = (n > 64) ? 10 : 15;
         for (int k = 0; k < limit; k++) begin
            if ($urandom_range(0, 9) < 8) begin
               s = ($urandom_range(0, 9) == 0) ? rnd32()
                   : lo + longint'($urandom_range(0, 32'(hi - lo)));
               d = ($urandom_range(0, 9) == 0) ? rnd32()
                   : longint'($urandom_range(0, 1 << 23)) - (1 <<< 22);
               send_item(mk(OpConvert, $urandom_range(0, 255), rnd32(), rnd32(),
                            rnd32(), s, d));
            end else begin
               send_item(mk(OpWrite, $urandom_range(0, 255), rnd32(), rnd32(),
                            rnd32(), rnd32(), rnd32()));
            end
         end
      end

      wait_idle();
      repeat (600) @(posedge clock);
      $display("tb_top: %0d transactions sent, %0d points checked over %0d table sizes",
               n_sent, n_points, counts.size() + 1);
      if (n_errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
design/f2c_pkg.sv
design/f2c_ram.sv
design/f2c_datapath.sv
design/f2c_control.sv
design/frenet_to_cartesian.sv
design/f2c_checker.sv
tb/tb_top.sv
